[rtl/rhc_pkg.sv]
// Shared types, widths and arithmetic helpers of the RGB/HSV converter.
package rhc_pkg;

  localparam int CH_W       = 8;             // channel width
  localparam int HUE_W      = 11;            // hue width, 0..1535
  localparam int FRAC_W     = 8;             // fraction bits of a hue sector
  localparam int TDATA_W    = 56;            // packed payload, whole bytes
  localparam int DIV_STEPS  = 9;             // quotient bits of the hue/sat divider
  localparam int BE_STAGES  = DIV_STEPS + 1; // back-end register stages before output

  localparam logic FUNC_TO_HSV = 1'b0;
  localparam logic FUNC_TO_RGB = 1'b1;

  localparam logic [1:0] OFF_RED   = 2'd0;
  localparam logic [1:0] OFF_GREEN = 2'd1;
  localparam logic [1:0] OFF_BLUE  = 2'd2;

  localparam logic [HUE_W:0]    HUE_TURN  = 12'd1536;
  localparam logic [15:0]       DEN_QT    = 16'd65280;
  localparam logic [CH_W:0]     SECT      = 9'd256;
  localparam logic [CH_W-1:0]   CMAX      = 8'd255;

  // Classified item handed from the front end to the back end.
  typedef struct packed {
    logic             func;
    logic             grey;
    logic             neg;
    logic [1:0]       off_code;
    logic [CH_W-1:0]  diff;
    logic [CH_W-1:0]  delta;
    logic [CH_W-1:0]  v;       // max for the forward path, value for the reverse path
    logic [2:0]       sector;
    logic [FRAC_W-1:0] frac;
    logic [CH_W-1:0]  sat;
  } cmd_t;

  // Truncated x / 255 for a 16-bit x: reciprocal estimate by 257/65536,
  // which is low by at most one, then a single correction.
  function automatic logic [CH_W-1:0] div255_est(input logic [15:0] x);
    logic [24:0] acc;
    acc = {1'b0, x, 8'b0} + {9'b0, x};
    return acc[23:16];
  endfunction

  function automatic logic [CH_W-1:0] div255_fix(input logic [15:0] x,
                                                 input logic [CH_W-1:0] est);
    logic [16:0] prod;
    logic [16:0] rem;
    prod = {1'b0, est, 8'b0} - {9'b0, est};
    rem  = {1'b0, x} - prod;
    return (rem >= 17'd255) ? est + 8'd1 : est;
  endfunction

endpackage

[rtl/rhc_front.sv]
// Front end: registers each pixel and classifies it for the back end.
module rhc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      ready_o,
  input  logic                      func_i,
  input  logic [rhc_pkg::TDATA_W-1:0] data_i,
  output logic                      push_o,
  input  logic                      full_i,
  output rhc_pkg::cmd_t             cmd_o
);
  import rhc_pkg::*;

  logic          valid_q;
  cmd_t          cmd_q, cmd_d;
  logic [CH_W-1:0] r, g, b, mx, mn, a, c;
  logic [HUE_W-1:0] hue;

  assign r   = data_i[7:0];
  assign g   = data_i[15:8];
  assign b   = data_i[23:16];
  assign hue = data_i[34:24];

  always_comb begin
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    cmd_d = '0;
    cmd_d.func  = func_i;
    cmd_d.delta = mx - mn;
    cmd_d.grey  = (mx == mn);
    if (mx == r) begin
      cmd_d.off_code = OFF_RED;
      a = g;
      c = b;
    end else if (mx == g) begin
      cmd_d.off_code = OFF_GREEN;
      a = b;
      c = r;
    end else begin
      cmd_d.off_code = OFF_BLUE;
      a = r;
      c = g;
    end
    cmd_d.neg  = (a < c);
    cmd_d.diff = (a < c) ? c - a : a - c;
    cmd_d.sector = hue[HUE_W-1:FRAC_W];
    cmd_d.frac   = hue[FRAC_W-1:0];
    cmd_d.sat    = data_i[42:35];
    cmd_d.v      = (func_i == FUNC_TO_RGB) ? data_i[50:43] : mx;
  end

  assign push_o  = valid_q && !full_i;
  assign ready_o = !valid_q || !full_i;
  assign cmd_o   = cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (push_o) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

[rtl/rhc_queue.sv]
// Two-entry queue of classified items between front and back end.
module rhc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  rhc_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output rhc_pkg::cmd_t cmd_o
);
  import rhc_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

endmodule

[rtl/rhc_back.sv]
// Back end: pipelined dividers and products, then the final result register.
module rhc_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        empty_i,
  input  rhc_pkg::cmd_t               cmd_i,
  output logic                        pop_o,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [rhc_pkg::TDATA_W-1:0] data_o
);
  import rhc_pkg::*;

  typedef struct packed {
    logic             func;
    logic             grey;
    logic             neg;
    logic [1:0]       off_code;
    logic [2:0]       sector;
    logic [CH_W-1:0]  v;
    logic [CH_W-1:0]  hdiv;
    logic [16:0]      hrem;
    logic [8:0]       hq;
    logic [16:0]      srem;
    logic [8:0]       sq;
    logic [15:0]      p_x;
    logic [15:0]      sf;
    logic [16:0]      sg;
    logic [23:0]      q_x;
    logic [23:0]      t_x;
    logic [CH_W-1:0]  pv;
    logic [CH_W-1:0]  qv;
    logic [CH_W-1:0]  tv;
  } stage_t;

  stage_t           pipe_q [BE_STAGES];
  stage_t           pipe_d [BE_STAGES];
  logic             vld_q  [BE_STAGES];
  logic             out_vld_q;
  logic [TDATA_W-1:0] out_q, out_d;
  logic             adv;
  logic [HUE_W-1:0] off, hue;
  logic [HUE_W:0]   hue_wrap;
  logic [CH_W-1:0]  ro, go, bo, so;
  stage_t           fin;

  // The whole back end moves as one pipeline whenever the output slot frees.
  assign adv     = !out_vld_q || ready_i;
  assign pop_o   = adv && !empty_i;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

  always_comb begin
    for (int k = 1; k < BE_STAGES; k++) begin
      pipe_d[k] = pipe_q[k-1];
    end
    // Entry stage: numerators and first products.
    pipe_d[0]          = '0;
    pipe_d[0].func     = cmd_i.func;
    pipe_d[0].grey     = cmd_i.grey;
    pipe_d[0].neg      = cmd_i.neg;
    pipe_d[0].off_code = cmd_i.off_code;
    pipe_d[0].sector   = cmd_i.sector;
    pipe_d[0].v        = cmd_i.v;
    pipe_d[0].hdiv     = cmd_i.delta;
    pipe_d[0].hrem     = {1'b0, cmd_i.diff, 8'b0};
    pipe_d[0].srem     = {1'b0, cmd_i.delta, 8'b0} - {9'b0, cmd_i.delta};
    pipe_d[0].p_x      = cmd_i.v * (CMAX - cmd_i.sat);
    pipe_d[0].sf       = cmd_i.sat * cmd_i.frac;
    pipe_d[0].sg       = cmd_i.sat * (SECT - {1'b0, cmd_i.frac});
    // One quotient bit of each divider per stage, most significant first.
    for (int k = 1; k < BE_STAGES; k++) begin
      if (pipe_q[k-1].hrem >= ({9'b0, pipe_q[k-1].hdiv} << (DIV_STEPS - k))) begin
        pipe_d[k].hrem = pipe_q[k-1].hrem - ({9'b0, pipe_q[k-1].hdiv} << (DIV_STEPS - k));
        pipe_d[k].hq   = {pipe_q[k-1].hq[7:0], 1'b1};
      end else begin
        pipe_d[k].hq   = {pipe_q[k-1].hq[7:0], 1'b0};
      end
      if (pipe_q[k-1].srem >= ({9'b0, pipe_q[k-1].v} << (DIV_STEPS - k))) begin
        pipe_d[k].srem = pipe_q[k-1].srem - ({9'b0, pipe_q[k-1].v} << (DIV_STEPS - k));
        pipe_d[k].sq   = {pipe_q[k-1].sq[7:0], 1'b1};
      end else begin
        pipe_d[k].sq   = {pipe_q[k-1].sq[7:0], 1'b0};
      end
    end
    // Reverse path: second products, then reciprocal estimates and corrections.
    pipe_d[1].q_x = pipe_q[0].v * (DEN_QT - pipe_q[0].sf);
    pipe_d[1].t_x = pipe_q[0].v * (DEN_QT - pipe_q[0].sg[15:0]);
    pipe_d[1].pv  = div255_est(pipe_q[0].p_x);
    pipe_d[2].pv  = div255_fix(pipe_q[1].p_x, pipe_q[1].pv);
    pipe_d[2].qv  = div255_est(pipe_q[1].q_x[23:8]);
    pipe_d[2].tv  = div255_est(pipe_q[1].t_x[23:8]);
    pipe_d[3].qv  = div255_fix(pipe_q[2].q_x[23:8], pipe_q[2].qv);
    pipe_d[3].tv  = div255_fix(pipe_q[2].t_x[23:8], pipe_q[2].tv);
  end

  // Final assembly of the result word.
  always_comb begin
    fin      = pipe_q[BE_STAGES-1];
    off      = {fin.off_code, 9'b0};
    hue_wrap = {1'b0, off} + HUE_TURN - {3'b0, fin.hq};
    if (fin.grey) begin
      hue = '0;
    end else if (!fin.neg) begin
      hue = off + {2'b0, fin.hq};
    end else if ({2'b0, fin.hq} > off) begin
      hue = hue_wrap[HUE_W-1:0];
    end else begin
      hue = off - {2'b0, fin.hq};
    end
    so = (fin.v == '0) ? '0 : fin.sq[CH_W-1:0];
    case (fin.sector)
      3'd1: begin ro = fin.qv; go = fin.v;  bo = fin.pv; end
      3'd2: begin ro = fin.pv; go = fin.v;  bo = fin.tv; end
      3'd3: begin ro = fin.pv; go = fin.qv; bo = fin.v;  end
      3'd4: begin ro = fin.tv; go = fin.pv; bo = fin.v;  end
      3'd5: begin ro = fin.v;  go = fin.pv; bo = fin.qv; end
      default: begin ro = fin.v; go = fin.tv; bo = fin.pv; end
    endcase
    if (fin.func == FUNC_TO_RGB) begin
      out_d = {5'b0, 8'b0, 8'b0, 11'b0, bo, go, ro};
    end else begin
      out_d = {5'b0, fin.v, so, hue, 8'b0, 8'b0, 8'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BE_STAGES; k++) vld_q[k] <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= !empty_i;
      for (int k = 1; k < BE_STAGES; k++) vld_q[k] <= vld_q[k-1];
      out_vld_q <= vld_q[BE_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < BE_STAGES; k++) pipe_q[k] <= pipe_d[k];
      out_q <= out_d;
    end
  end

endmodule

[rtl/rgb_hsv_converter_core.sv]
// Top level of the per-pixel RGB/HSV converter.
//
//  channel   dir  handshake                      payload
//  s_axis    in   s_axis_tvalid / s_axis_tready  tdata: pixel, tuser: func
//  m_axis    out  m_axis_tvalid / m_axis_tready  tdata: converted pixel
//
// One pixel is accepted per clock when the output is taken every clock.
// From input transfer to output valid the path runs through one front-end
// register, one queue slot, ten back-end stages set by the nine-bit
// restoring dividers of hue and saturation, and the output register.
// Reset clears all valid flags and the queue; payload registers are not reset.
// A stall on m_axis freezes the back end; the queue and front register keep
// accepting up to three more pixels before s_axis_tready drops.
module rgb_hsv_converter_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // [7:0] in_red, [15:8] in_green, [23:16] in_blue, [34:24] in_hue,
  // [42:35] in_sat, [50:43] in_val, rest zero
  input  logic [rhc_pkg::TDATA_W-1:0] s_axis_tdata,
  // [0] func
  input  logic                        s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [34:24] out_hue,
  // [42:35] out_sat, [50:43] out_val, rest zero
  output logic [rhc_pkg::TDATA_W-1:0] m_axis_tdata
);
  import rhc_pkg::*;

  cmd_t fe_cmd, q_cmd;
  logic push, full, pop, empty;

  // Front end classifies the pixel: max/min, hue sector offset, sign of the
  // hue difference, or the sector and fraction of an incoming hue.
  rhc_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .func_i  (s_axis_tuser),
    .data_i  (s_axis_tdata),
    .push_o  (push),
    .full_i  (full),
    .cmd_o   (fe_cmd)
  );

  // The queue lets the front end keep taking pixels while the back end stalls.
  rhc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (fe_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .cmd_o   (q_cmd)
  );

  // The back end runs the divisions and products and drives the output.
  rhc_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .cmd_i   (q_cmd),
    .pop_o   (pop),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (m_axis_tdata)
  );

endmodule
